/* src/pbfs_pkg.sv */
// shared types and constants for the packet buffer free stack
package pbfs_pkg;

	// field widths
	localparam int ADDR_W    = 48;
	localparam int SIZE_W    = 22;
	localparam int ENTRIES_W = 13;
	localparam int INDEX_W   = 12;
	localparam int COUNT_W   = 6;
	localparam int GRANT_W   = 7;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = INDEX_W + SIZE_W;

	// operation codes
	localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd2;

	// buffer size used when the register holds zero
	localparam logic [SIZE_W-1:0] DEFAULT_BUFFER_SIZE = 22'd2048;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_ALLOC
	} state_t;

	// one pop (or empty grant) travelling down the address pipeline
	typedef struct packed {
		logic               valid;
		logic               grant_valid;
		logic               last;
		logic               short_grant;
		logic [GRANT_W-1:0] granted;
	} pop_tok_t;

endpackage

/* src/pbfs_stack_ram.sv */
// free index stack storage: one write port, one registered read port
module pbfs_stack_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/pbfs_ctrl.sv */
// stack controller: top of stack, init sweep, push on free and pop sequencing
module pbfs_ctrl #(
	parameter int POOL_DEPTH = 4096,
	parameter int MAX_BATCH  = 32,
	parameter int AW         = 12,
	parameter int TW         = 13,
	parameter int CW         = 13
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [pbfs_pkg::OP_W-1:0]       operation,
	input  logic [pbfs_pkg::COUNT_W-1:0]    request_count,
	input  logic [pbfs_pkg::INDEX_W-1:0]    freed_index,
	input  logic [pbfs_pkg::ENTRIES_W-1:0]  pool_entries,
	output logic [TW-1:0]                   stack_top,
	output logic                            ram_we,
	output logic [AW-1:0]                   ram_waddr,
	output logic [pbfs_pkg::INDEX_W-1:0]    ram_wdata,
	output logic                            ram_re,
	output logic [AW-1:0]                   ram_raddr,
	output pbfs_pkg::pop_tok_t              tok_s1
);

	pbfs_pkg::state_t state_q, state_d;

	logic [TW-1:0]                      top_q, top_d, top_m1;
	logic [TW-1:0]                      fill_q, fill_d, fill_p1;
	logic [pbfs_pkg::GRANT_W-1:0]       remain_q, remain_d;
	logic [pbfs_pkg::GRANT_W-1:0]       granted_q, granted_d;
	logic                               short_q, short_d;
	pbfs_pkg::pop_tok_t                 tok_d;

	logic                               accept;
	logic [CW-1:0]                      limit;
	logic [pbfs_pkg::GRANT_W-1:0]       want;
	logic [pbfs_pkg::GRANT_W-1:0]       grant;
	logic                               grant_short;
	logic                               push_ok;

	assign busy      = (state_q != pbfs_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign stack_top = top_q;
	assign top_m1    = top_q - TW'(1);
	assign fill_p1   = fill_q + TW'(1);

	// pool size in use, clamped to the storage depth
	assign limit = (CW'(pool_entries) > CW'(POOL_DEPTH)) ? CW'(POOL_DEPTH) : CW'(pool_entries);

	// batch clamp, then clamp to the free count
	assign want = (pbfs_pkg::GRANT_W'(request_count) > pbfs_pkg::GRANT_W'(MAX_BATCH)) ?
		pbfs_pkg::GRANT_W'(MAX_BATCH) : pbfs_pkg::GRANT_W'(request_count);
	assign grant = (CW'(top_q) < CW'(want)) ? pbfs_pkg::GRANT_W'(top_q) : want;
	assign grant_short = (grant < pbfs_pkg::GRANT_W'(request_count));

	// push only with room below the pool size and an index inside the pool
	assign push_ok = (CW'(top_q) < limit) && (CW'(freed_index) < limit);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pbfs_pkg::ST_IDLE: begin
				if (accept && operation == pbfs_pkg::OP_INIT && limit != '0) begin
					state_d = pbfs_pkg::ST_INIT;
				end else if (accept && operation == pbfs_pkg::OP_ALLOC && grant != '0) begin
					state_d = pbfs_pkg::ST_ALLOC;
				end
			end
			pbfs_pkg::ST_INIT: begin
				if (fill_p1 == top_q) begin
					state_d = pbfs_pkg::ST_IDLE;
				end
			end
			pbfs_pkg::ST_ALLOC: begin
				if (remain_q == pbfs_pkg::GRANT_W'(1)) begin
					state_d = pbfs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pbfs_pkg::ST_IDLE;
			end
		endcase
	end

	// memory accesses and datapath updates
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = top_q[AW-1:0];
		ram_wdata = freed_index;
		ram_re    = 1'b0;
		ram_raddr = top_m1[AW-1:0];
		top_d     = top_q;
		fill_d    = fill_q;
		remain_d  = remain_q;
		granted_d = granted_q;
		short_d   = short_q;
		tok_d     = '0;
		case (state_q)
			pbfs_pkg::ST_IDLE: begin
				if (accept) begin
					case (operation)
						pbfs_pkg::OP_INIT: begin
							top_d  = TW'(limit);
							fill_d = '0;
						end
						pbfs_pkg::OP_FREE: begin
							if (push_ok) begin
								ram_we = 1'b1;
								top_d  = top_q + TW'(1);
							end
						end
						pbfs_pkg::OP_ALLOC: begin
							granted_d = grant;
							remain_d  = grant;
							short_d   = grant_short;
							// nothing granted: a single empty result
							if (grant == '0) begin
								tok_d.valid       = 1'b1;
								tok_d.grant_valid = 1'b0;
								tok_d.last        = 1'b1;
								tok_d.short_grant = grant_short;
								tok_d.granted     = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			pbfs_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = fill_q[AW-1:0];
				ram_wdata = pbfs_pkg::INDEX_W'(fill_q);
				fill_d    = fill_p1;
			end
			pbfs_pkg::ST_ALLOC: begin
				ram_re            = 1'b1;
				top_d             = top_m1;
				remain_d          = remain_q - pbfs_pkg::GRANT_W'(1);
				tok_d.valid       = 1'b1;
				tok_d.grant_valid = 1'b1;
				tok_d.last        = (remain_q == pbfs_pkg::GRANT_W'(1));
				tok_d.short_grant = short_q;
				tok_d.granted     = granted_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pbfs_pkg::ST_IDLE;
			top_q    <= '0;
			fill_q   <= '0;
			remain_q <= '0;
			tok_s1   <= '0;
		end else begin
			state_q  <= state_d;
			top_q    <= top_d;
			fill_q   <= fill_d;
			remain_q <= remain_d;
			tok_s1   <= tok_d;
		end
	end

	// batch attributes held for the pops
	always_ff @(posedge clk) begin
		granted_q <= granted_d;
		short_q   <= short_d;
	end

endmodule

/* src/pbfs_addr_pipe.sv */
// address pipeline: index times buffer size, then plus base, into the result registers
module pbfs_addr_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pbfs_pkg::pop_tok_t            tok_s1,
	input  logic [pbfs_pkg::INDEX_W-1:0]  rdata,
	input  logic [pbfs_pkg::ADDR_W-1:0]   base_address,
	input  logic [pbfs_pkg::SIZE_W-1:0]   buffer_size,
	output logic                          result_strobe,
	output logic [pbfs_pkg::ADDR_W-1:0]   buffer_address,
	output logic [pbfs_pkg::INDEX_W-1:0]  buffer_index,
	output logic [pbfs_pkg::COUNT_W-1:0]  granted_count,
	output logic                          grant_valid,
	output logic                          short_grant,
	output logic                          last_result
);

	pbfs_pkg::pop_tok_t               tok_s2;
	logic [pbfs_pkg::INDEX_W-1:0]     idx_s1;
	logic [pbfs_pkg::INDEX_W-1:0]     idx_s2;
	logic [pbfs_pkg::PROD_W-1:0]      prod_s2;

	logic                             strobe_q;
	logic [pbfs_pkg::ADDR_W-1:0]      addr_q;
	logic [pbfs_pkg::INDEX_W-1:0]     index_q;
	logic [pbfs_pkg::COUNT_W-1:0]     count_q;
	logic                             gvalid_q;
	logic                             short_q;
	logic                             last_q;

	// empty grants carry index zero
	assign idx_s1 = tok_s1.grant_valid ? rdata : '0;

	// stage 2: offset product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
		end else begin
			tok_s2 <= tok_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2  <= idx_s1;
		prod_s2 <= pbfs_pkg::PROD_W'(idx_s1) * pbfs_pkg::PROD_W'(buffer_size);
	end

	// stage 3: base add and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= tok_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		addr_q   <= tok_s2.grant_valid ?
			(base_address + pbfs_pkg::ADDR_W'(prod_s2)) : '0;
		index_q  <= idx_s2;
		count_q  <= pbfs_pkg::COUNT_W'(tok_s2.granted);
		gvalid_q <= tok_s2.grant_valid;
		short_q  <= tok_s2.short_grant;
		last_q   <= tok_s2.last;
	end

	assign result_strobe  = strobe_q;
	assign buffer_address = addr_q;
	assign buffer_index   = index_q;
	assign granted_count  = count_q;
	assign grant_valid    = gvalid_q;
	assign short_grant    = short_q;
	assign last_result    = last_q;

endmodule

/* src/packet_buffer_free_stack.sv */
// Packet buffer pool allocator kept as a stack of free buffer indices in one
// synchronous RAM. An item is taken when start is high and busy is low. A free
// is done in the cycle it is taken. An init writes the indices 0 to n-1 with
// one RAM write a cycle, n being the pool size in use, and busy stays high
// until the last write. An allocate of g buffers keeps busy high until its
// last pop, one pop a cycle through the single RAM read port; its results
// follow on result_strobe, one per cycle, behind the RAM read, through the
// product stage and the result registers, for g results, or one result with
// grant_valid low when nothing is granted. Results must be taken as they
// come: there is no way to hold them off. Configuration writes are always
// ready and belong in idle periods only.
module packet_buffer_free_stack #(
	parameter int POOL_DEPTH = 4096,
	parameter int MAX_BATCH  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command channel
	input  logic                            start,
	output logic                            busy,
	input  logic [pbfs_pkg::OP_W-1:0]       operation,
	input  logic [pbfs_pkg::COUNT_W-1:0]    request_count,
	input  logic [pbfs_pkg::INDEX_W-1:0]    freed_index,
	// configuration channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pbfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbfs_pkg::ADDR_W-1:0]     cfg_data,
	// results
	output logic                            result_strobe,
	output logic [pbfs_pkg::ADDR_W-1:0]     buffer_address,
	output logic [pbfs_pkg::INDEX_W-1:0]    buffer_index,
	output logic [pbfs_pkg::COUNT_W-1:0]    granted_count,
	output logic                            grant_valid,
	output logic                            short_grant,
	output logic                            last_result
);

	localparam int AW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int TW  = $clog2(POOL_DEPTH + 1);
	localparam int CW  = (TW > pbfs_pkg::ENTRIES_W) ? TW : pbfs_pkg::ENTRIES_W;

	logic [pbfs_pkg::ADDR_W-1:0]    base_q;
	logic [pbfs_pkg::SIZE_W-1:0]    size_q;
	logic [pbfs_pkg::ENTRIES_W-1:0] entries_q;
	logic [pbfs_pkg::SIZE_W-1:0]    size_eff;

	logic [TW-1:0]                  stack_top;
	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [pbfs_pkg::INDEX_W-1:0]   ram_wdata;
	logic                           ram_re;
	logic [AW-1:0]                  ram_raddr;
	logic [pbfs_pkg::INDEX_W-1:0]   ram_rdata;
	pbfs_pkg::pop_tok_t             tok_s1;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			size_q    <= pbfs_pkg::DEFAULT_BUFFER_SIZE;
			entries_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pbfs_pkg::REG_BASE:    base_q    <= cfg_data;
				pbfs_pkg::REG_SIZE:    size_q    <= cfg_data[pbfs_pkg::SIZE_W-1:0];
				pbfs_pkg::REG_ENTRIES: entries_q <= cfg_data[pbfs_pkg::ENTRIES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// zero size falls back to the default
	assign size_eff = (size_q == '0) ? pbfs_pkg::DEFAULT_BUFFER_SIZE : size_q;

	pbfs_ctrl #(
		.POOL_DEPTH (POOL_DEPTH),
		.MAX_BATCH  (MAX_BATCH),
		.AW         (AW),
		.TW         (TW),
		.CW         (CW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.request_count (request_count),
		.freed_index   (freed_index),
		.pool_entries  (entries_q),
		.stack_top     (stack_top),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.tok_s1        (tok_s1)
	);

	pbfs_stack_ram #(
		.DEPTH (POOL_DEPTH),
		.AW    (AW),
		.DW    (pbfs_pkg::INDEX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pbfs_addr_pipe u_pipe (
		.clk            (clk),
		.arst_n         (arst_n),
		.tok_s1         (tok_s1),
		.rdata          (ram_rdata),
		.base_address   (base_q),
		.buffer_size    (size_eff),
		.result_strobe  (result_strobe),
		.buffer_address (buffer_address),
		.buffer_index   (buffer_index),
		.granted_count  (granted_count),
		.grant_valid    (grant_valid),
		.short_grant    (short_grant),
		.last_result    (last_result)
	);

`ifndef NO_ASSERTIONS
	// an empty grant is a single, all-zero, final result
	a_empty_grant: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !grant_valid |->
			last_result && granted_count == '0 && buffer_address == '0 && buffer_index == '0)
		else $error("empty grant result malformed");

	// results of one batch arrive in consecutive cycles
	a_batch_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && grant_valid && !last_result |=> result_strobe && grant_valid)
		else $error("gap inside an allocate batch");

	// the stack never grows past its storage
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(stack_top) <= CW'(POOL_DEPTH))
		else $error("stack top beyond pool depth");

	// a free leaves the controller idle and moves the top by at most one
	a_free_single: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == pbfs_pkg::OP_FREE |=>
			!busy && (stack_top == $past(stack_top) || stack_top == $past(stack_top) + TW'(1)))
		else $error("free misbehaved");
`endif

endmodule
